// ----- rtl/vdb_pkg.sv -----
// Shared widths, constants and arctangent table for the distance and bearing pipeline.
package vdb_pkg;

    // CORDIC datapath: differences are scaled to about 2^35, grown by the CORDIC gain.
    localparam int XW        = 39;
    // Angle accumulator in degrees * 2^20.
    localparam int ZW        = 32;
    localparam int TABLE_LEN = 24;
    // Stages beyond the table are not run.
    localparam int MAX_STAGES = TABLE_LEN;
    // Split of the clamped x for the gain multiply.
    localparam int XLO_W     = 19;
    localparam int XHI_W     = XW - 1 - XLO_W;
    localparam int GAIN_W    = 24;
    localparam int PROD_W    = XLO_W + GAIN_W;
    localparam int SUM_W     = XHI_W + GAIN_W + XLO_W + 1;

    localparam int DIST_W    = 17;
    localparam int BRG_W     = 16;
    localparam int OUT_BITS  = DIST_W + BRG_W;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [GAIN_W-1:0]  GAIN_Q24      = 24'd10188014;
    localparam logic signed [ZW-1:0] DEG180_Q20  = 32'sd188743680;
    localparam logic signed [ZW-1:0] BRG_ROUND   = 32'sd4096;
    localparam int                 BRG_SHIFT     = 13;
    localparam logic [DIST_W-1:0]  DIST_MAX      = 17'd131071;
    localparam logic signed [BRG_W-1:0] BRG_LIMIT = 16'sd23040;

    // atan(2^-i) in degrees * 2^20, rounded to nearest
    localparam logic signed [ZW-1:0] ATAN_DEG_Q20 [TABLE_LEN] = '{
        32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
        32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
        32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
        32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
        32'sd917,      32'sd458,      32'sd229,      32'sd115,
        32'sd57,       32'sd29,       32'sd14,       32'sd7
    };

endpackage

// ----- rtl/vdb_cordic_stage.sv -----
// One registered vectoring CORDIC micro-rotation.
module vdb_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [vdb_pkg::XW-1:0]    i_x,
    input  logic signed [vdb_pkg::XW-1:0]    i_y,
    input  logic signed [vdb_pkg::ZW-1:0]    i_z,
    output logic signed [vdb_pkg::XW-1:0]    o_x,
    output logic signed [vdb_pkg::XW-1:0]    o_y,
    output logic signed [vdb_pkg::ZW-1:0]    o_z
);

    logic signed [vdb_pkg::XW-1:0] xs;
    logic signed [vdb_pkg::XW-1:0] ys;
    logic signed [vdb_pkg::XW-1:0] n_x;
    logic signed [vdb_pkg::XW-1:0] n_y;
    logic signed [vdb_pkg::ZW-1:0] n_z;
    logic signed [vdb_pkg::XW-1:0] r_x;
    logic signed [vdb_pkg::XW-1:0] r_y;
    logic signed [vdb_pkg::ZW-1:0] r_z;

    // arithmetic shift floors toward minus infinity
    assign xs = i_x >>> SHIFT;
    assign ys = i_y >>> SHIFT;

    always_comb begin
        if (i_y > 0) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + vdb_pkg::ATAN_DEG_Q20[SHIFT];
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - vdb_pkg::ATAN_DEG_Q20[SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ----- rtl/vector_distance_and_bearing.sv -----
// Top level: pipelined vectoring CORDIC giving distance and bearing between two points.
// Throughput: one request per cycle while the output is accepted; one register stage
//   per CORDIC micro-rotation, plus difference, prep, gain-multiply and output stages.
// Each stage loads when it is empty or its successor moves, so bubbles collapse and
//   requests keep entering while a finished result waits on the output.
// Reset (i_rst_n low, synchronous) clears every stage valid bit; data registers hold.
module vector_distance_and_bearing #(
    parameter int CORDIC_STAGES = 16,
    parameter int COORD_BITS    = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // from_x, from_y, to_x, to_y (COORD_BITS each, signed), zero pad to bytes
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // distance (17, unsigned), bearing (16, signed), zero pad to bytes
    output logic [vdb_pkg::OUT_W-1:0]              m_axis_tdata
);

    localparam int NS    = (CORDIC_STAGES < vdb_pkg::MAX_STAGES) ?
                           CORDIC_STAGES : vdb_pkg::MAX_STAGES;
    localparam int GUARD = 35 - COORD_BITS;
    localparam int DW    = COORD_BITS + 1;
    // stage map: 0 difference, 1 prep, 2..NS+1 CORDIC, NS+2 multiply, NS+3 output
    localparam int MUL_ST = NS + 2;
    localparam int L      = NS + 4;
    localparam int DSH    = vdb_pkg::GAIN_W + GUARD;
    localparam logic [vdb_pkg::SUM_W-1:0] HALF = vdb_pkg::SUM_W'(1) << (DSH - 1);

    // ---------------------------------------------------------------
    // Flow control: per-stage valid and load enable
    // ---------------------------------------------------------------
    logic [L-1:0] r_vld;
    logic [L:0]   en;

    assign en[L] = m_axis_tready;

    genvar k;
    generate
        for (k = 0; k < L; k++) begin : g_flow
            // load when empty, or when the current content moves on
            assign en[k] = !r_vld[k] || en[k+1];
            if (k == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_vld[k] <= 1'b0;
                    end else if (en[k]) begin
                        r_vld[k] <= s_axis_tvalid;
                    end
                end
            end else begin : g_rest
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_vld[k] <= 1'b0;
                    end else if (en[k]) begin
                        r_vld[k] <= r_vld[k-1];
                    end
                end
            end
        end
    endgenerate

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = r_vld[L-1];

    // ---------------------------------------------------------------
    // Stage 0: coordinate differences, exact in COORD_BITS+1 bits
    // ---------------------------------------------------------------
    logic signed [COORD_BITS-1:0] from_x, from_y, to_x, to_y;
    logic signed [DW-1:0]         n_dx, n_dy;
    logic signed [DW-1:0]         r_dx, r_dy;
    logic [MUL_ST:0]              r_zero;

    assign from_x = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
    assign from_y = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
    assign to_x   = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
    assign to_y   = s_axis_tdata[3*COORD_BITS +: COORD_BITS];

    assign n_dx = DW'(to_x) - DW'(from_x);
    assign n_dy = DW'(to_y) - DW'(from_y);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_dx      <= n_dx;
            r_dy      <= n_dy;
            // coincident points: force both results to zero at the end
            r_zero[0] <= (n_dx == '0) && (n_dy == '0);
        end
    end

    // carry the coincidence flag alongside the datapath
    generate
        for (k = 1; k <= MUL_ST; k++) begin : g_zero
            always_ff @(posedge i_clk) begin
                if (en[k]) begin
                    r_zero[k] <= r_zero[k-1];
                end
            end
        end
    endgenerate

    // ---------------------------------------------------------------
    // Stage 1: fold the left half plane, scale up, seed the angle
    // ---------------------------------------------------------------
    logic signed [vdb_pkg::XW-1:0] cx [NS+1];
    logic signed [vdb_pkg::XW-1:0] cy [NS+1];
    logic signed [vdb_pkg::ZW-1:0] cz [NS+1];
    logic signed [vdb_pkg::XW-1:0] dx_ext, dy_ext;
    logic signed [vdb_pkg::XW-1:0] n_px, n_py;
    logic signed [vdb_pkg::ZW-1:0] n_pz;
    logic signed [vdb_pkg::XW-1:0] r_px, r_py;
    logic signed [vdb_pkg::ZW-1:0] r_pz;

    assign dx_ext = vdb_pkg::XW'(r_dx);
    assign dy_ext = vdb_pkg::XW'(r_dy);

    always_comb begin
        if (r_dx < 0) begin
            n_px = (-dx_ext) <<< GUARD;
            n_py = (-dy_ext) <<< GUARD;
            // start from +180 on or above the axis, -180 below it
            n_pz = (r_dy >= 0) ? vdb_pkg::DEG180_Q20 : -vdb_pkg::DEG180_Q20;
        end else begin
            n_px = dx_ext <<< GUARD;
            n_py = dy_ext <<< GUARD;
            n_pz = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_px <= n_px;
            r_py <= n_py;
            r_pz <= n_pz;
        end
    end

    assign cx[0] = r_px;
    assign cy[0] = r_py;
    assign cz[0] = r_pz;

    // ---------------------------------------------------------------
    // Stages 2..NS+1: one micro-rotation each
    // ---------------------------------------------------------------
    generate
        for (k = 0; k < NS; k++) begin : g_cordic
            vdb_cordic_stage #(
                .SHIFT (k)
            ) u_stage (
                .i_clk (i_clk),
                .i_en  (en[k+2]),
                .i_x   (cx[k]),
                .i_y   (cy[k]),
                .i_z   (cz[k]),
                .o_x   (cx[k+1]),
                .o_y   (cy[k+1]),
                .o_z   (cz[k+1])
            );
        end
    endgenerate

    // ---------------------------------------------------------------
    // Multiply stage: gain partial products, bearing rounding and clamp
    // ---------------------------------------------------------------
    logic [vdb_pkg::XW-2:0]          x_pos;
    logic [vdb_pkg::PROD_W-1:0]      n_plo, n_phi;
    logic [vdb_pkg::PROD_W-1:0]      r_plo, r_phi;
    logic signed [vdb_pkg::ZW-1:0]   z_rnd;
    logic signed [vdb_pkg::BRG_W-1:0] n_brg, r_brg;

    // drop a negative x to zero
    assign x_pos = cx[NS][vdb_pkg::XW-1] ? '0 : cx[NS][vdb_pkg::XW-2:0];
    assign n_plo = vdb_pkg::PROD_W'(x_pos[vdb_pkg::XLO_W-1:0]) *
                   vdb_pkg::PROD_W'(vdb_pkg::GAIN_Q24);
    assign n_phi = vdb_pkg::PROD_W'(x_pos[vdb_pkg::XW-2:vdb_pkg::XLO_W]) *
                   vdb_pkg::PROD_W'(vdb_pkg::GAIN_Q24);

    // nearest, ties upward, then clamp to +/-180 degrees
    assign z_rnd = (cz[NS] + vdb_pkg::BRG_ROUND) >>> vdb_pkg::BRG_SHIFT;

    always_comb begin
        priority if (z_rnd > vdb_pkg::ZW'(vdb_pkg::BRG_LIMIT)) begin
            n_brg = vdb_pkg::BRG_LIMIT;
        end else if (z_rnd < -vdb_pkg::ZW'(vdb_pkg::BRG_LIMIT)) begin
            n_brg = -vdb_pkg::BRG_LIMIT;
        end else begin
            n_brg = z_rnd[vdb_pkg::BRG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[MUL_ST]) begin
            r_plo <= n_plo;
            r_phi <= n_phi;
            r_brg <= n_brg;
        end
    end

    // ---------------------------------------------------------------
    // Output stage: sum partial products, round, saturate, zero coincident points, register
    // ---------------------------------------------------------------
    logic [vdb_pkg::SUM_W-1:0]  prod_sum;
    logic [vdb_pkg::SUM_W-1:0]  dist_full;
    logic [vdb_pkg::DIST_W-1:0] n_dist, r_dist;
    logic signed [vdb_pkg::BRG_W-1:0] n_obrg, r_obrg;

    assign prod_sum  = (vdb_pkg::SUM_W'(r_phi) << vdb_pkg::XLO_W) +
                       vdb_pkg::SUM_W'(r_plo) + HALF;
    assign dist_full = prod_sum >> DSH;

    always_comb begin
        priority if (r_zero[MUL_ST]) begin
            n_dist = '0;
            n_obrg = '0;
        end else if (dist_full > vdb_pkg::SUM_W'(vdb_pkg::DIST_MAX)) begin
            n_dist = vdb_pkg::DIST_MAX;
            n_obrg = r_brg;
        end else begin
            n_dist = dist_full[vdb_pkg::DIST_W-1:0];
            n_obrg = r_brg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[L-1]) begin
            r_dist <= n_dist;
            r_obrg <= n_obrg;
        end
    end

    assign m_axis_tdata = {{(vdb_pkg::OUT_W - vdb_pkg::OUT_BITS){1'b0}}, r_obrg, r_dist};

endmodule

// ----- rtl/vdb_checker.sv -----
// Port-level checker for the distance and bearing pipeline, bound to the top level.
module vdb_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [vdb_pkg::OUT_W-1:0]         m_axis_tdata
);

    logic signed [vdb_pkg::BRG_W-1:0]  brg;
    logic [vdb_pkg::DIST_W-1:0]        range_val;

    assign range_val = m_axis_tdata[vdb_pkg::DIST_W-1:0];
    assign brg       = m_axis_tdata[vdb_pkg::OUT_BITS-1:vdb_pkg::DIST_W];

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // an empty output stage never blocks requests
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("request refused with empty output");

    // bearing stays within +/-180 degrees
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (brg <= vdb_pkg::BRG_LIMIT) && (brg >= -vdb_pkg::BRG_LIMIT))
        else $error("bearing out of range");

    // a zero distance, as from coincident points, must come with a zero bearing
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (range_val == '0) |-> (brg == '0))
        else $error("zero distance with nonzero bearing");

endmodule

bind vector_distance_and_bearing vdb_checker u_vdb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for the point-pair distance and bearing pipeline.
module tb_top;

    localparam int STAGES        = 16;
    localparam int COORD_W       = 16;
    localparam int IN_W          = ((4 * COORD_W + 7) / 8) * 8;
    localparam int SCALE_SHIFT   = 35 - COORD_W;
    localparam int PIPE_DEPTH    = STAGES + 4;
    localparam int RESET_CYCLES  = 5;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_OFF_LEN  = 200;
    localparam int PRINT_LIMIT   = 40;

    localparam longint          HALF_TURN_Q20 = 64'sd188743680;
    localparam longint unsigned RANGE_GAIN    = 64'd10188014;
    localparam longint unsigned RANGE_CEIL    = 64'd131071;
    localparam longint          BEARING_CEIL  = 64'sd23040;

    typedef struct packed {
        logic [16:0]        distance;
        logic signed [15:0] bearing;
    } range_bearing_t;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [IN_W-1:0]             s_axis_tdata  = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [vdb_pkg::OUT_W-1:0]   m_axis_tdata;

    range_bearing_t expected_fixes[$];
    range_bearing_t want_fix;
    int             error_count    = 0;
    int             result_count   = 0;
    int             quiet_cycles   = 0;
    bit             sender_gaps    = 1'b1;
    bit             receiver_gaps  = 1'b1;
    int             hold_off_left  = 0;
    int             rx_stall_left  = 0;

    always #5 i_clk = ~i_clk;

    vector_distance_and_bearing #(
        .CORDIC_STAGES (STAGES),
        .COORD_BITS    (COORD_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // atan(2^-i) in degrees scaled by 2^20
    function automatic longint atan_step_q20(input int i);
        case (i)
            0:  return 47185920;
            1:  return 27855475;
            2:  return 14718068;
            3:  return 7471121;
            4:  return 3750058;
            5:  return 1876857;
            6:  return 938658;
            7:  return 469357;
            8:  return 234682;
            9:  return 117342;
            10: return 58671;
            11: return 29335;
            12: return 14668;
            13: return 7334;
            14: return 3667;
            15: return 1833;
            16: return 917;
            17: return 458;
            18: return 229;
            19: return 115;
            20: return 57;
            21: return 29;
            22: return 14;
            default: return 7;
        endcase
    endfunction

    // Vectoring CORDIC on B - A: x converges to the gain-scaled length, z to the angle.
    function automatic range_bearing_t compute_range_bearing(
        input logic signed [15:0] ax, ay, bx, by
    );
        longint          dx, dy, x, y, z, xs, ys, brg;
        longint unsigned len;
        range_bearing_t  fix;
        dx = longint'(bx) - longint'(ax);
        dy = longint'(by) - longint'(ay);
        fix = '0;
        if (dx == 0 && dy == 0)
            return fix;
        z = 0;
        // Fold the left half plane onto the right; dy = 0 there counts as +180.
        if (dx < 0) begin
            z  = (dy >= 0) ? HALF_TURN_Q20 : -HALF_TURN_Q20;
            dx = -dx;
            dy = -dy;
        end
        x = dx * (64'sd1 <<< SCALE_SHIFT);
        y = dy * (64'sd1 <<< SCALE_SHIFT);
        for (int i = 0; i < STAGES && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step_q20(i);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step_q20(i);
            end
        end
        if (x < 0)
            x = 0;
        len = ($unsigned(x) * RANGE_GAIN + (64'd1 << (23 + SCALE_SHIFT))) >> (24 + SCALE_SHIFT);
        if (len > RANGE_CEIL)
            len = RANGE_CEIL;
        brg = (z + 4096) >>> 13;
        if (brg > BEARING_CEIL)
            brg = BEARING_CEIL;
        if (brg < -BEARING_CEIL)
            brg = -BEARING_CEIL;
        fix.distance = len[16:0];
        fix.bearing  = brg[15:0];
        return fix;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (error_count < PRINT_LIMIT)
            $display("result %0d: %s got %0d want %0d", result_count, what, got, want);
        error_count++;
    endtask

    // Offer one request, optionally after a gap; queue its expected fix once taken.
    task automatic send_points(input logic [15:0] ax, ay, bx, by);
        int gap;
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {by, bx, ay, ax};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_fixes.push_back(compute_range_bearing(ax, ay, bx, by));
    endtask

    function automatic logic [15:0] pick_corner();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            4:       return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    // Axes, quadrants, coincident points and the widest differences.
    task automatic test_directed();
        send_points(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_points(16'h1234, 16'hfedc, 16'h1234, 16'hfedc);
        send_points(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_points(16'h0000, 16'h0000, 16'h0010, 16'h0000);
        send_points(16'h0000, 16'h0000, 16'hfff0, 16'h0000);
        send_points(16'h0000, 16'h0000, 16'h0000, 16'h0010);
        send_points(16'h0000, 16'h0000, 16'h0000, 16'hfff0);
        send_points(16'h0000, 16'h0000, 16'h0001, 16'h0000);
        send_points(16'h0000, 16'h0000, 16'hffff, 16'h0000);
        send_points(16'h0000, 16'h0000, 16'hffff, 16'hffff);
        send_points(16'h0000, 16'h0000, 16'hffff, 16'h0001);
        send_points(16'h0000, 16'h0000, 16'h0020, 16'h0020);
        send_points(16'h0000, 16'h0000, 16'hffe0, 16'h0020);
        send_points(16'h0000, 16'h0000, 16'hffe0, 16'hffe0);
        send_points(16'h0000, 16'h0000, 16'h0020, 16'hffe0);
        send_points(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        send_points(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
        send_points(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_points(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        send_points(16'h8000, 16'h0000, 16'h7fff, 16'h0000);
        send_points(16'h7fff, 16'h0000, 16'h8000, 16'h0000);
        send_points(16'h0000, 16'h8000, 16'h0000, 16'h7fff);
        send_points(16'h0000, 16'h7fff, 16'h0000, 16'h8000);
    endtask

    // Mix wide random pairs with near, axis-aligned, coincident and corner cases.
    task automatic test_random_pairs(input int count);
        logic [15:0] ax, ay, bx, by;
        int          mode;
        repeat (count) begin
            mode = $urandom_range(0, 9);
            ax = 16'($urandom);
            ay = 16'($urandom);
            bx = 16'($urandom);
            by = 16'($urandom);
            case (mode)
                5, 6: begin
                    bx = ax + 16'($urandom_range(0, 64)) - 16'd32;
                    by = ay + 16'($urandom_range(0, 64)) - 16'd32;
                end
                7: begin
                    if ($urandom_range(0, 1)) bx = ax;
                    else                      by = ay;
                end
                8: begin
                    bx = ax;
                    by = ay;
                end
                9: begin
                    ax = pick_corner();
                    ay = pick_corner();
                    bx = pick_corner();
                    by = pick_corner();
                end
                default: ;
            endcase
            send_points(ax, ay, bx, by);
        end
    endtask

    // Hold the output off long enough for the pipeline to fill and stall its input.
    task automatic test_output_hold_off();
        sender_gaps   = 1'b0;
        hold_off_left = HOLD_OFF_LEN;
        test_random_pairs(48);
        sender_gaps   = 1'b1;
    endtask

    // Send random pairs with no gaps on either side.
    task automatic test_back_to_back();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        test_random_pairs(60);
    endtask

    // Receiver: long hold-off when asked, else random stall bursts.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_off_left--;
            end else if (rx_stall_left > 0) begin
                m_axis_tready <= 1'b0;
                rx_stall_left--;
            end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                rx_stall_left = $urandom_range(1, 10) - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each result with the oldest expected fix.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_fixes.size() == 0) begin
                report_mismatch("unexpected result, data", m_axis_tdata, 0);
            end else begin
                want_fix = expected_fixes.pop_front();
                if (m_axis_tdata[16:0] !== want_fix.distance)
                    report_mismatch("distance", m_axis_tdata[16:0], want_fix.distance);
                if (m_axis_tdata[32:17] !== want_fix.bearing)
                    report_mismatch("bearing", $signed(m_axis_tdata[32:17]),
                                    want_fix.bearing);
                if (m_axis_tdata[vdb_pkg::OUT_W-1:33] !== '0)
                    report_mismatch("pad bits", m_axis_tdata[vdb_pkg::OUT_W-1:33], 0);
            end
            result_count++;
        end
    end

    // Abort when nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_pairs(300);
        test_output_hold_off();
        test_back_to_back();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_fixes.size() != 0) @(posedge i_clk);
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
